[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned CounterBits  = 16;
  localparam int unsigned OverflowBits = 6;
  localparam int unsigned ScaleBits    = 10;
  localparam int unsigned TrigBits     = 16;
  localparam int unsigned DistBits     = 23;
  localparam int unsigned TotalBits    = OverflowBits + CounterBits;
  localparam int unsigned ProdBits     = TotalBits + ScaleBits;

  // total*scale/1000 = ((total*scale) >> 3) / 125, the /125 as a reciprocal multiply
  localparam int unsigned DivInBits   = ProdBits - 3;
  localparam int unsigned RecipBits   = 30;
  localparam int unsigned RecipShift  = 36;
  localparam logic [RecipBits-1:0] RecipM = 30'd549755814;
  localparam int unsigned RecipProdBits = DivInBits + RecipBits;

  localparam logic [ScaleBits-1:0] ScaleReset = 10'd170;
  localparam logic [TrigBits-1:0]  TrigReset  = 16'd15;

  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = 32;

  typedef enum logic [0:0] {
    CFG_SCALE = 1'b0,
    CFG_TRIG  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CAP_WAIT = 3'b001,
    CAP_HIGH = 3'b010,
    CAP_DONE = 3'b100
  } cap_phase_e;

  typedef enum logic [2:0] {
    TRG_IDLE = 3'b001,
    TRG_LEAD = 3'b010,
    TRG_HIGH = 3'b100
  } trg_phase_e;

  typedef struct packed {
    logic trigger_level;
    logic distance_valid;
    logic capture_done;
    logic timed_out;
  } res_t;

endpackage

[rtl/ultrasonic_echo_ranger.sv]
// Top level of the ultrasonic echo ranger: config registers, capture core, distance pipeline.
//
// One input transaction per timer tick on s_axis: tdata[0] is the sampled echo level,
// tdata[1] a measure request. Each tick yields exactly one output transaction on
// m_axis carrying the trigger pin level, the latched distance and the capture flags.
// Capture state steps in the cycle a tick is accepted; the distance
// (overflows*65536 + count)*scale/1000 is finished by a three-register pipeline
// (scale multiply, reciprocal multiply for /1000). One tick per cycle is sustained
// while m_axis_tready is high; the two multipliers set the depth.
// A stalled m_axis holds its data; stages fill behind it and s_axis_tready drops
// only once all three stages are occupied.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once and are
// expected only while the block is idle: index 0 scale_numerator, 1 trigger_ticks.
// Reset (rst_ni low, asynchronous) clears capture and trigger state, the held
// distance, and empties the pipeline; the registers return to 170 and 15.
module ultrasonic_echo_ranger (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] echo_level, [1] start_request, [7:2] zero
  input  logic [uer_pkg::InDataBits-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] trigger_level, [23:1] distance, [24] distance_valid, [25] capture_done,
  // [26] timed_out, [31:27] zero
  output logic [uer_pkg::OutDataBits-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [uer_pkg::TrigBits-1:0]    cfg_wdata_i
);
  import uer_pkg::*;

  logic [ScaleBits-1:0] scale_q;
  logic [TrigBits-1:0]  trig_q;

  logic                 accept;
  res_t                 res;
  logic [TotalBits-1:0] total;

  logic                     v1_q, v2_q, v3_q;
  res_t                     r1_q, r2_q, r3_q;
  logic [TotalBits-1:0]     tot1_q;
  logic [ScaleBits-1:0]     scl1_q;
  logic [ProdBits-1:0]      prod2_q;
  logic [RecipProdBits-1:0] prod3_q;
  logic [DistBits-1:0]      dist_q;
  logic [DistBits-1:0]      quot;
  logic [DistBits-1:0]      dist_out;
  logic                     rdy1, rdy2, rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      trig_q  <= TrigReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCALE: scale_q <= cfg_wdata_i[ScaleBits-1:0];
        CFG_TRIG:  trig_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rdy3   = !v3_q || m_axis_tready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign accept = s_axis_tvalid && rdy1;

  uer_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .echo_i       (s_axis_tdata[0]),
    .req_i        (s_axis_tdata[1]),
    .trig_ticks_i (trig_q),
    .res_o        (res),
    .total_o      (total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      r1_q   <= res;
      tot1_q <= total;
      scl1_q <= scale_q;
    end
    if (rdy2) begin
      r2_q    <= r1_q;
      prod2_q <= ProdBits'(tot1_q) * ProdBits'(scl1_q);
    end
    if (rdy3) begin
      r3_q    <= r2_q;
      prod3_q <= RecipProdBits'(prod2_q[ProdBits-1:3]) * RecipProdBits'(RecipM);
    end
  end

  assign quot     = prod3_q[RecipShift +: DistBits];
  assign dist_out = r3_q.distance_valid ? quot : dist_q;

  // held distance follows each readout as it leaves the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (v3_q && m_axis_tready && r3_q.distance_valid) begin
      dist_q <= quot;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {5'b0, r3_q.timed_out, r3_q.capture_done,
                          r3_q.distance_valid, dist_out, r3_q.trigger_level};

endmodule

[rtl/uer_capture.sv]
// Echo pulse capture and trigger sequencer, stepped once per accepted tick.
module uer_capture (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         echo_i,
  input  logic                         req_i,
  input  logic [uer_pkg::TrigBits-1:0] trig_ticks_i,
  output uer_pkg::res_t                res_o,
  output logic [uer_pkg::TotalBits-1:0] total_o
);
  import uer_pkg::*;

  cap_phase_e                cap_q, cap_d;
  logic [OverflowBits-1:0]   ovf_q, ovf_d;
  logic [CounterBits-1:0]    cnt_q, cnt_d;
  logic [CounterBits-1:0]    capt_q, capt_d;
  logic                      prev_q, prev_d;
  trg_phase_e                trg_q, trg_d;
  logic [TrigBits-1:0]       tmr_q, tmr_d;
  logic                      tout_q, tout_d;

  logic                      rising, falling, wrap;
  logic [TrigBits-1:0]       trig_len;
  trg_phase_e                trg_a;
  logic [TrigBits-1:0]       tmr_a, tmr_b;
  logic                      valid;

  assign trig_len = (trig_ticks_i == '0) ? TrigBits'(1) : trig_ticks_i;

  always_comb begin
    cap_d   = cap_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    capt_d  = capt_q;
    tout_d  = tout_q;
    prev_d  = echo_i;
    valid   = 1'b0;
    total_o = '0;
    rising  = echo_i & ~prev_q;
    falling = ~echo_i & prev_q;
    wrap    = (cnt_q == '1);

    // edge detection and counting
    if (cap_q != CAP_DONE && rising) begin
      cap_d  = CAP_HIGH;
      ovf_d  = '0;
      capt_d = '0;
      tout_d = 1'b0;
      cnt_d  = '0;
    end else begin
      if (cap_q == CAP_HIGH) begin
        if (falling) begin
          capt_d = cnt_q;
          cap_d  = CAP_DONE;
        end else if (wrap) begin
          if (ovf_q == '1) begin
            capt_d = '1;
            cap_d  = CAP_DONE;
            tout_d = 1'b1;
          end else begin
            ovf_d = ovf_q + OverflowBits'(1);
          end
        end
      end
      cnt_d = cnt_q + CounterBits'(1);
    end

    // start request: trigger launch and readout
    trg_a = trg_q;
    tmr_a = tmr_q;
    if (req_i && trg_q == TRG_IDLE) begin
      trg_a = TRG_LEAD;
      tmr_a = trig_len;
      if (cap_d == CAP_DONE) begin
        total_o = {ovf_d, capt_d};
        valid   = 1'b1;
        cap_d   = CAP_WAIT;
        ovf_d   = '0;
        capt_d  = '0;
      end
    end

    // trigger sequencer; lead phase counts the request tick
    trg_d = TRG_IDLE;
    tmr_d = tmr_a;
    tmr_b = (tmr_a != '0) ? tmr_a - TrigBits'(1) : tmr_a;
    res_o.trigger_level = 1'b0;
    if (trg_a == TRG_LEAD || trg_a == TRG_HIGH) begin
      res_o.trigger_level = (trg_a == TRG_HIGH);
      tmr_d = tmr_b;
      trg_d = trg_a;
      if (tmr_b == '0) begin
        if (trg_a == TRG_LEAD) begin
          trg_d = TRG_HIGH;
          tmr_d = trig_len;
        end else begin
          trg_d = TRG_IDLE;
        end
      end
    end

    res_o.distance_valid = valid;
    res_o.capture_done   = (cap_d == CAP_DONE);
    res_o.timed_out      = tout_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_WAIT;
      ovf_q  <= '0;
      cnt_q  <= '0;
      capt_q <= '0;
      prev_q <= 1'b0;
      trg_q  <= TRG_IDLE;
      tmr_q  <= '0;
      tout_q <= 1'b0;
    end else if (step_i) begin
      cap_q  <= cap_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
      capt_q <= capt_d;
      prev_q <= prev_d;
      trg_q  <= trg_d;
      tmr_q  <= tmr_d;
      tout_q <= tout_d;
    end
  end

endmodule

[rtl/uer_checker.sv]
// Port-level assertions for the ultrasonic echo ranger, bound to the top level.
module uer_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [uer_pkg::OutDataBits-1:0] m_axis_tdata
);
  import uer_pkg::*;

  // output channel empty while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled transaction keeps its data
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // readout rearms the capture
  a_readout_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> !m_axis_tdata[25])
    else $error("capture still done on readout tick");

  // readout tick starts the low lead, so the trigger is low
  a_readout_trig_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> !m_axis_tdata[0])
    else $error("trigger high on readout tick");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
